[sv/sparse_vector_run_decoder_core_defines.svh]
// Assertion macros used by the property checker module svrd_props.
`ifndef SPARSE_VECTOR_RUN_DECODER_CORE_DEFINES_SVH
`define SPARSE_VECTOR_RUN_DECODER_CORE_DEFINES_SVH

// Implication checked only out of reset.
`define SVRD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("svrd check failed");

// Next-cycle implication checked only out of reset.
`define SVRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("svrd check failed");

// Next-cycle implication that also holds across reset.
`define SVRD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("svrd check failed");

`endif

[sv/svrd_pkg.sv]
package svrd_pkg;

    localparam int CountBits = 32;
    localparam int FifoDepth = 4;
    localparam int FifoAw = $clog2(FifoDepth);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COUNT,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        REG_VECTOR_LENGTH = 2'd0,
        REG_SWAP_BYTE_ORDER = 2'd1,
        REG_MISSING_VALUE_BITS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [31:0] repeat_count;
        logic        vector_done;
        logic        last_for_byte;
        logic        error_code;
    } res_t;

    localparam logic [63:0] OneBits = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] MissingReset = 64'd9221120237041090560;
    localparam logic [4:0] CodeCount1 = 5'd0;
    localparam logic [4:0] CodeCount2 = 5'd30;
    localparam logic [4:0] CodeCount4 = 5'd31;
    localparam logic [1:0] TypeOnes = 2'd0;
    localparam logic [1:0] TypeByte = 2'd1;
    localparam logic [1:0] TypeFloat = 2'd2;

endpackage

[sv/sparse_vector_run_decoder_core.sv]
// Order: a result caused by a byte is registered into the result queue at the byte's transaction
//   and shows on the m_ side once all earlier results are taken; a second result follows its first.
// Throughput: one byte per cycle while results drain; a four-entry result queue takes up to
//   two results per byte and holds s_ready low when fewer than two entries are free.
// Reset (aresetn low, synchronous): parser back to expecting a header, queue emptied,
//   registers back to vector_length 1, no byte swap, missing value a quiet NaN.
module sparse_vector_run_decoder_core
    import svrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // compressed byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // decoded results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value_bits,
    output logic [31:0] m_repeat_count,
    output logic        m_vector_done,
    output logic        m_last_for_byte,
    output logic        m_error_code
);

    // Widen a float to a double exactly; subnormals are normalized by a priority search.
    function automatic logic [63:0] widen_float(input logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  p;
        logic [22:0] m_sh;
        logic [63:0] r;
        e = f[30:23];
        m = f[22:0];
        p = '0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) begin
                p = 5'(i);
            end
        end
        m_sh = m << (5'd22 - p);
        if (e == 8'hFF) begin
            if (m == '0) begin
                r = {f[31], 11'h7FF, 52'd0};
            end else begin
                // quiet bit set, payload moved up into the double mantissa
                r = {f[31], 11'h7FF, 1'b1, m[21:0], 29'd0};
            end
        end else if (e == 8'd0) begin
            if (m == '0) begin
                r = {f[31], 63'd0};
            end else begin
                r = {f[31], 11'(11'd874 + 11'(p)), m_sh[21:0], 30'd0};
            end
        end else begin
            r = {f[31], 11'(11'(e) + 11'd896), m, 29'd0};
        end
        return r;
    endfunction

    // Signed byte to double; code -128 maps to the configured missing value.
    function automatic logic [63:0] byte_to_double(input logic [7:0] b,
                                                   input logic [63:0] missing);
        logic [7:0]  mag;
        logic [2:0]  p;
        logic [6:0]  mag_sh;
        logic [63:0] r;
        mag = b[7] ? 8'(8'd0 - b) : b;
        p = '0;
        for (int i = 0; i < 7; i++) begin
            if (mag[i]) begin
                p = 3'(i);
            end
        end
        mag_sh = mag[6:0] << (3'd6 - p);
        if (b == 8'h80) begin
            r = missing;
        end else if (mag == '0) begin
            r = '0;
        end else begin
            r = {b[7], 11'(11'd1023 + 11'(p)), mag_sh[5:0], 46'd0};
        end
        return r;
    endfunction

    // configuration registers
    logic [31:0] vlen_reg;
    logic        swap_reg;
    logic [63:0] missing_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] val_reg, val_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] rem_reg, rem_next;
    logic        clamp_reg, clamp_next;

    // result queue
    res_t              fifo_reg [FifoDepth];
    logic [FifoAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FifoAw:0]   count_reg;

    // working values of one byte
    logic        accept;
    logic        pop;
    logic        fin_go;
    logic [31:0] fin_n;
    logic        fin_stop;
    logic [31:0] rem_w;
    logic [7:0]  hdr_w;
    logic [31:0] acc_w;
    logic [63:0] val_w;
    logic [31:0] left_w;
    logic [2:0]  cidx_inc;
    logic [3:0]  vidx_inc;
    logic [2:0]  csize;
    logic [3:0]  vsize;
    logic        run_clamp;
    logic [31:0] take;
    logic [63:0] bits;
    logic        e0_v, e1_v;
    res_t        e0, e1;
    logic [1:0]  push_cnt;

    assign cfg_ready = 1'b1;
    assign accept = s_valid && s_ready;
    assign pop = m_valid && m_ready;
    // keep room for the two results a single byte may cause
    assign s_ready = (count_reg <= (FifoAw + 1)'(FifoDepth - 2));
    assign m_valid = (count_reg != '0);

    assign m_value_bits    = fifo_reg[rd_ptr_reg].value_bits;
    assign m_repeat_count  = fifo_reg[rd_ptr_reg].repeat_count;
    assign m_vector_done   = fifo_reg[rd_ptr_reg].vector_done;
    assign m_last_for_byte = fifo_reg[rd_ptr_reg].last_for_byte;
    assign m_error_code    = fifo_reg[rd_ptr_reg].error_code;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        left_next  = left_reg;
        clamp_next = clamp_reg;
        hdr_w      = hdr_reg;
        rem_w      = rem_reg;
        fin_go     = 1'b0;
        fin_n      = '0;
        fin_stop   = 1'b0;
        acc_w      = acc_reg;
        val_w      = val_reg;
        left_w     = left_reg;
        run_clamp  = 1'b0;
        take       = '0;
        bits       = '0;
        e0_v       = 1'b0;
        e1_v       = 1'b0;
        e0         = '0;
        e1         = '0;
        cidx_inc   = 3'({1'b0, idx_reg[1:0]} + 3'd1);
        vidx_inc   = 4'({1'b0, idx_reg} + 4'd1);
        unique case (hdr_reg[4:0])
            CodeCount1: csize = 3'd1;
            CodeCount2: csize = 3'd2;
            default:    csize = 3'd4;
        endcase
        unique case (hdr_reg[6:5])
            TypeByte:  vsize = 4'd1;
            TypeFloat: vsize = 4'd4;
            default:   vsize = 4'd8;
        endcase

        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    // start of a vector: load the length, zero counts as one
                    if (rem_reg == '0) begin
                        rem_w = (vlen_reg == '0) ? 32'd1 : vlen_reg;
                    end
                    hdr_w = s_in_byte;
                    if (s_in_byte[4:0] == CodeCount1 || s_in_byte[4:0] == CodeCount2 ||
                        s_in_byte[4:0] == CodeCount4) begin
                        phase_next = PH_COUNT;
                        idx_next   = '0;
                        acc_next   = '0;
                    end else begin
                        fin_go = 1'b1;
                        fin_n  = {27'd0, s_in_byte[4:0]};
                    end
                end
                PH_COUNT: begin
                    if (swap_reg) begin
                        acc_w = {acc_reg[23:0], s_in_byte};
                    end else begin
                        acc_w = acc_reg | (32'(s_in_byte) << {idx_reg[1:0], 3'b000});
                    end
                    acc_next = acc_w;
                    idx_next = cidx_inc;
                    if (cidx_inc >= csize) begin
                        fin_go   = 1'b1;
                        fin_n    = 32'(acc_w[CountBits-1:0]);
                        idx_next = '0;
                    end
                end
                PH_VALUE: begin
                    if (swap_reg) begin
                        val_w = {val_reg[55:0], s_in_byte};
                    end else begin
                        val_w = val_reg | (64'(s_in_byte) << {idx_reg, 3'b000});
                    end
                    if (vidx_inc >= vsize) begin
                        priority case (vsize)
                            4'd1:    bits = byte_to_double(val_w[7:0], missing_reg);
                            4'd4:    bits = widen_float(val_w[31:0]);
                            default: bits = val_w;
                        endcase
                        val_next = '0;
                        idx_next = '0;
                        left_w = (left_reg != '0) ? 32'(left_reg - 32'd1) : left_reg;
                        rem_w  = (rem_reg != '0) ? 32'(rem_reg - 32'd1) : rem_reg;
                        e0_v = 1'b1;
                        e0.value_bits   = bits;
                        e0.repeat_count = 32'd1;
                        e0.vector_done  = (rem_w == '0);
                        e0.error_code   = (rem_w == '0) && clamp_reg;
                        if (left_w == '0 || rem_w == '0) begin
                            left_next  = '0;
                            clamp_next = 1'b0;
                            phase_next = PH_HEADER;
                        end else begin
                            left_next = left_w;
                        end
                    end else begin
                        val_next = val_w;
                        idx_next = vidx_inc[2:0];
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase

            // count is known: emit the zero run if header bit 7 is set, then the ones run or open the values
            if (fin_go) begin
                phase_next = PH_HEADER;
                if (hdr_w[7]) begin
                    if (fin_n != '0) begin
                        run_clamp = fin_n > rem_w;
                        take  = run_clamp ? rem_w : fin_n;
                        rem_w = 32'(rem_w - take);
                        e0_v = 1'b1;
                        e0.value_bits   = '0;
                        e0.repeat_count = take;
                        e0.vector_done  = (rem_w == '0);
                        e0.error_code   = run_clamp;
                    end
                    // zeros that end the vector drop the trailing value
                    fin_stop = (rem_w == '0);
                    fin_n    = 32'd1;
                end
                if (!fin_stop && fin_n != '0) begin
                    run_clamp = fin_n > rem_w;
                    take = run_clamp ? rem_w : fin_n;
                    if (hdr_w[6:5] == TypeOnes) begin
                        rem_w = 32'(rem_w - take);
                        if (e0_v) begin
                            e1_v = 1'b1;
                            e1.value_bits   = OneBits;
                            e1.repeat_count = take;
                            e1.vector_done  = (rem_w == '0);
                            e1.error_code   = run_clamp;
                        end else begin
                            e0_v = 1'b1;
                            e0.value_bits   = OneBits;
                            e0.repeat_count = take;
                            e0.vector_done  = (rem_w == '0);
                            e0.error_code   = run_clamp;
                        end
                    end else begin
                        left_next  = take;
                        clamp_next = run_clamp;
                        idx_next   = '0;
                        val_next   = '0;
                        phase_next = PH_VALUE;
                    end
                end
            end

            // tag the final result of this byte
            if (e1_v) begin
                e1.last_for_byte = 1'b1;
            end else if (e0_v) begin
                e0.last_for_byte = 1'b1;
            end
        end

        hdr_next = hdr_w;
        rem_next = rem_w;
        push_cnt = {1'b0, e0_v} + {1'b0, e1_v};
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlen_reg    <= 32'd1;
            swap_reg    <= 1'b0;
            missing_reg <= MissingReset;
        end else if (cfg_valid && cfg_ready) begin
            priority case (cfg_index)
                REG_VECTOR_LENGTH:      vlen_reg    <= cfg_data[31:0];
                REG_SWAP_BYTE_ORDER:    swap_reg    <= cfg_data[0];
                REG_MISSING_VALUE_BITS: missing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hdr_reg   <= '0;
            acc_reg   <= '0;
            idx_reg   <= '0;
            val_reg   <= '0;
            left_reg  <= '0;
            rem_reg   <= '0;
            clamp_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            val_reg   <= val_next;
            left_reg  <= left_next;
            rem_reg   <= rem_next;
            clamp_reg <= clamp_next;
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (e0_v) begin
            fifo_reg[wr_ptr_reg] <= e0;
        end
        if (e1_v) begin
            fifo_reg[FifoAw'(wr_ptr_reg + 1'b1)] <= e1;
        end
    end

    // result queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= FifoAw'(wr_ptr_reg + FifoAw'(push_cnt));
            if (pop) begin
                rd_ptr_reg <= FifoAw'(rd_ptr_reg + 1'b1);
            end
            count_reg <= (FifoAw + 1)'(count_reg + (FifoAw + 1)'(push_cnt)
                                       - (FifoAw + 1)'(pop));
        end
    end

endmodule

[sv/svrd_checker.sv]
`include "sparse_vector_run_decoder_core_defines.svh"

module svrd_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_repeat_count,
    input logic        m_vector_done,
    input logic        m_error_code
);

    // a clamped run always closes its vector
    `SVRD_ASSERT_IMP(a_err_done, aclk, aresetn, m_valid && m_error_code, m_vector_done)
    // every result stands for at least one value
    `SVRD_ASSERT_IMP(a_rep_nonzero, aclk, aresetn, m_valid, m_repeat_count != 32'd0)
    // a stalled result stays offered
    `SVRD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // reset empties the result side
    `SVRD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind sparse_vector_run_decoder_core svrd_props u_svrd_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_repeat_count(m_repeat_count),
    .m_vector_done (m_vector_done),
    .m_error_code  (m_error_code)
);

[bench/svrd_checker.sv]
`timescale 1ns / 1ps

module svrd_checker
    import svrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_value_bits,
    input  logic [31:0] m_repeat_count,
    input  logic        m_vector_done,
    input  logic        m_last_for_byte,
    input  logic        m_error_code,
    output int          mismatches,
    output int          pending,
    output int          results_checked
);

    localparam logic [63:0] MantMask = 64'h000F_FFFF_FFFF_FFFF;

    // register copies
    logic [31:0] vec_len;
    logic        swap_order;
    logic [63:0] missing_bits;

    // parser copy
    phase_t      phase;
    logic [7:0]  hdr;
    logic [31:0] count_acc;
    logic [2:0]  field_idx;
    logic [63:0] value_acc;
    logic [31:0] run_left;
    logic [31:0] remaining;
    logic        clamped;

    res_t decoded_q[$];

    assign pending = decoded_q.size();

    function automatic logic [63:0] widen_single(logic [31:0] f);
        logic [63:0] sgn;
        logic [7:0]  ex;
        logic [63:0] man;
        int          p;
        sgn = {f[31], 63'b0};
        ex = f[30:23];
        man = {41'b0, f[22:0]};
        p = 22;
        if (ex == 8'hFF) begin
            if (man == 0) return sgn | 64'h7FF0_0000_0000_0000;
            return sgn | 64'h7FF8_0000_0000_0000 | (man << 29);
        end
        if (ex == 8'h00) begin
            if (man == 0) return sgn;
            while (p > 0 && !man[p]) p--;
            man = (man << (52 - p)) & MantMask;
            return sgn | (64'(p + 874) << 52) | man;
        end
        return sgn | (64'(ex + 896) << 52) | (man << 29);
    endfunction

    function automatic logic [63:0] byte_as_double(logic [7:0] b);
        logic [63:0] sgn;
        logic [63:0] mag;
        int          p;
        sgn = 64'b0;
        p = 6;
        if (b == 8'h80) return missing_bits;
        if (b[7]) begin
            sgn = {1'b1, 63'b0};
            mag = 64'(9'd256 - b);
        end else begin
            mag = 64'(b);
        end
        if (mag == 0) return 64'b0;
        while (p > 0 && !mag[p]) p--;
        return sgn | (64'(1023 + p) << 52) | ((mag << (52 - p)) & MantMask);
    endfunction

    function automatic void push_result(logic [63:0] bits, logic [31:0] rep,
                                        logic done, logic err);
        res_t r;
        r.value_bits = bits;
        r.repeat_count = rep;
        r.vector_done = done;
        r.last_for_byte = 1'b0;
        r.error_code = err;
        decoded_q.push_back(r);
    endfunction

    // Close a count: emit zero and ones runs, or arm the value phase.
    function automatic void close_count(logic [31:0] n);
        logic [31:0] take;
        logic        clamp;
        phase = PH_HEADER;
        if (hdr[7]) begin
            if (n > 0) begin
                clamp = n > remaining;
                take = clamp ? remaining : n;
                remaining = remaining - take;
                push_result(64'b0, take, remaining == 0, clamp);
            end
            if (remaining == 0) return;
            n = 1;
        end
        if (n == 0) return;
        clamp = n > remaining;
        take = clamp ? remaining : n;
        if (hdr[6:5] == TypeOnes) begin
            remaining = remaining - take;
            push_result(OneBits, take, remaining == 0, clamp);
            return;
        end
        run_left = take;
        clamped = clamp;
        field_idx = 0;
        value_acc = 0;
        phase = PH_VALUE;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int          first;
        int          size;
        logic [4:0]  code;
        logic [2:0]  idx;
        logic [63:0] bits;
        first = decoded_q.size();
        if (phase == PH_HEADER) begin
            code = b[4:0];
            if (remaining == 0) remaining = (vec_len == 0) ? 32'd1 : vec_len;
            hdr = b;
            if (code == CodeCount1 || code == CodeCount2 || code == CodeCount4) begin
                phase = PH_COUNT;
                field_idx = 0;
                count_acc = 0;
            end else begin
                close_count(32'(code));
            end
        end else if (phase == PH_COUNT) begin
            code = hdr[4:0];
            size = (code == CodeCount1) ? 1 : ((code == CodeCount2) ? 2 : 4);
            idx = {1'b0, field_idx[1:0]};
            if (swap_order) count_acc = {count_acc[23:0], b};
            else count_acc = count_acc | (32'(b) << (8 * idx));
            field_idx = idx + 3'd1;
            if (int'(field_idx) >= size) begin
                field_idx = 0;
                close_count(count_acc);
            end
        end else begin
            size = (hdr[6:5] == TypeByte) ? 1 : ((hdr[6:5] == TypeFloat) ? 4 : 8);
            idx = field_idx;
            if (swap_order) value_acc = {value_acc[55:0], b};
            else value_acc = value_acc | (64'(b) << (8 * idx));
            field_idx = idx + 3'd1;
            if (int'(idx) + 1 >= size) begin
                if (size == 1) bits = byte_as_double(value_acc[7:0]);
                else if (size == 4) bits = widen_single(value_acc[31:0]);
                else bits = value_acc;
                field_idx = 0;
                value_acc = 0;
                if (run_left > 0) run_left--;
                if (remaining > 0) remaining--;
                push_result(bits, 32'd1, remaining == 0, remaining == 0 && clamped);
                if (run_left == 0 || remaining == 0) begin
                    run_left = 0;
                    clamped = 1'b0;
                    phase = PH_HEADER;
                end
            end
        end
        if (decoded_q.size() > first)
            decoded_q[decoded_q.size() - 1].last_for_byte = 1'b1;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        mismatches = 0;
        results_checked = 0;
    end

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            vec_len <= 32'd1;
            swap_order <= 1'b0;
            missing_bits <= MissingReset;
            phase = PH_HEADER;
            hdr = 0;
            count_acc = 0;
            field_idx = 0;
            value_acc = 0;
            run_left = 0;
            remaining = 0;
            clamped = 1'b0;
            decoded_q.delete();
        end else begin
            // check the oldest outstanding result before this edge's byte adds new ones
            if (m_valid && m_ready) begin
                results_checked++;
                if (decoded_q.size() == 0) begin
                    $error("result with nothing outstanding: value_bits %h", m_value_bits);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("value_bits", want.value_bits, m_value_bits);
                    compare_field("repeat_count", 64'(want.repeat_count), 64'(m_repeat_count));
                    compare_field("vector_done", 64'(want.vector_done), 64'(m_vector_done));
                    compare_field("last_for_byte", 64'(want.last_for_byte),
                                  64'(m_last_for_byte));
                    compare_field("error_code", 64'(want.error_code), 64'(m_error_code));
                end
            end
            if (s_valid && s_ready) decode_byte(s_in_byte);
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_VECTOR_LENGTH: vec_len <= cfg_data[31:0];
                    REG_SWAP_BYTE_ORDER: swap_order <= cfg_data[0];
                    REG_MISSING_VALUE_BITS: missing_bits <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[bench/sparse_vector_run_decoder_core_test.sv]
`timescale 1ns / 1ps

module sparse_vector_run_decoder_core_test;
    import svrd_pkg::*;

    localparam int ByteTarget = 1700;
    localparam int SettleCycles = 6;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value_bits;
    logic [31:0] m_repeat_count;
    logic        m_vector_done;
    logic        m_last_for_byte;
    logic        m_error_code;

    int mismatches;
    int pending;
    int results_checked;
    int bytes_sent;
    int settings_run;
    logic no_stall;   // high during the stretch where neither side idles
    logic cur_swap;   // byte order the generator encodes with

    sparse_vector_run_decoder_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_byte(s_in_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_value_bits(m_value_bits),
        .m_repeat_count(m_repeat_count), .m_vector_done(m_vector_done),
        .m_last_for_byte(m_last_for_byte), .m_error_code(m_error_code)
    );

    svrd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_byte(s_in_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_value_bits(m_value_bits),
        .m_repeat_count(m_repeat_count), .m_vector_done(m_vector_done),
        .m_last_for_byte(m_last_for_byte), .m_error_code(m_error_code),
        .mismatches(mismatches), .pending(pending), .results_checked(results_checked)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: stall about a third of the time, except in the quiet stretch.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= no_stall || ($urandom_range(99) >= 32);
    end

    // Send one byte transaction; hold it until accepted.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = (!no_stall && $urandom_range(99) < 32) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        bytes_sent++;
    endtask

    // Drain: drop valid, wait for all outstanding results, then let the parser settle.
    task automatic drain_results();
        int guard;
        s_valid <= 1'b0;
        guard = 0;
        do begin
            @(negedge aclk);
            guard++;
        end while (pending != 0 && guard < 100000);
        @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [31:0] len, logic swap, logic [63:0] missing);
        drain_results();
        write_reg(REG_VECTOR_LENGTH, 64'(len));
        write_reg(REG_SWAP_BYTE_ORDER, 64'(swap));
        write_reg(REG_MISSING_VALUE_BITS, missing);
        cur_swap = swap;
        settings_run++;
    endtask

    // Send a multi-byte field in the byte order the block expects.
    task automatic send_field(logic [63:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(cur_swap ? v[8 * (nbytes - 1 - i) +: 8] : v[8 * i +: 8]);
    endtask

    function automatic logic [31:0] pick_single();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 31'b0};
            1: return {1'($urandom_range(1)), 8'h00, 23'($urandom_range(32'h7F_FFFF, 1))};
            2: return {1'($urandom_range(1)), 8'hFF, 23'b0};
            3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
            4: return {1'($urandom_range(1)), 8'h00, 23'(1 << $urandom_range(22))};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] pick_small_int();
        case ($urandom_range(5))
            0: return 8'h80;
            1: return 8'h00;
            2: return $urandom_range(1) ? 8'h7F : 8'h81;
            default: return 8'($urandom());
        endcase
    endfunction

    // One run: header, optional count field, then the value bytes for at most four values.
    task automatic send_run();
        logic [7:0]  hdr;
        logic [1:0]  vtype;
        logic [4:0]  code;
        logic [31:0] n;
        int          nvals;
        int          csize;
        vtype = 2'($urandom_range(3));
        case ($urandom_range(9))
            0: begin code = CodeCount1; csize = 1; end
            1: begin code = CodeCount2; csize = 2; end
            2: begin code = CodeCount4; csize = 4; end
            3: begin code = 5'($urandom_range(29, 1)); csize = 0; end
            default: begin code = 5'($urandom_range(4, 1)); csize = 0; end
        endcase
        if (csize == 0) n = 32'(code);
        else if ($urandom_range(9) == 0) n = $urandom() >> (8 * (4 - csize));
        else n = $urandom_range(5);
        hdr = {1'($urandom_range(99) < 30), vtype, code};
        send_byte(hdr);
        if (csize > 0) send_field(64'(n), csize);
        if (hdr[7]) nvals = 1;
        else if (vtype == TypeOnes) nvals = 0;
        else nvals = (n > 4) ? 4 : int'(n);
        for (int i = 0; i < nvals; i++) begin
            if (vtype == TypeByte) send_byte(pick_small_int());
            else if (vtype == TypeFloat) send_field(64'(pick_single()), 4);
            else if (vtype == TypeOnes) send_byte(8'($urandom()));
            else send_field({$urandom(), $urandom()}, 8);
        end
    endtask

    task automatic run_random(int target);
        while (bytes_sent < target) begin
            // occasional stray byte to knock the parser off a clean boundary
            if ($urandom_range(99) < 5) send_byte(8'($urandom()));
            else send_run();
        end
    endtask

    initial begin
        logic [7:0] directed[$];
        int step;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_in_byte = '0;
        no_stall = 1'b0;
        cur_swap = 1'b0;
        bytes_sent = 0;
        settings_run = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: inline ones, zeros plus a value, -128 and the byte extremes,
        // float subnormal and NaN, zero counts, and an overrun.
        apply_setting(32'd60, 1'b0, MissingReset);
        directed = '{8'h03, 8'h83, 8'h22, 8'h80, 8'h7F,
                     8'h21, 8'hFF,
                     8'h41, 8'h01, 8'h00, 8'h00, 8'h00,
                     8'h41, 8'h01, 8'h00, 8'hC0, 8'h7F,
                     8'h00, 8'h00,
                     8'h80, 8'h00,
                     8'h9D, 8'h9D, 8'h21, 8'h05};
        foreach (directed[i]) send_byte(directed[i]);

        // Random phases over several register settings, extremes included.
        for (step = 0; step < 6; step++) begin
            case (step)
                0: apply_setting(32'd1, 1'b1, 64'd0);
                1: apply_setting(32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
                2: apply_setting(32'hFFFF_FFFF, 1'b1, MissingReset);
                3: apply_setting(32'($urandom_range(40, 2)), 1'b0,
                                 {$urandom(), $urandom()});
                4: apply_setting(32'($urandom_range(12, 3)), 1'b1,
                                 {$urandom(), $urandom()});
                default: apply_setting(32'($urandom_range(200, 20)), 1'b0, MissingReset);
            endcase
            no_stall = (step == 3);
            run_random(25 + (step + 1) * (ByteTarget / 6));
            no_stall = 1'b0;
        end

        drain_results();
        $display("Sent %0d bytes under %0d register settings; checked %0d results.",
                 bytes_sent, settings_run, results_checked);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
